[hw/rtl/pnpp_pkg.sv]
package pnpp_pkg;
   localparam int ImgWidth = 128;
   localparam int ImgHeight = 128;
   localparam int ColBits = $clog2(ImgWidth);
   localparam int RowBits = $clog2(ImgHeight);
   localparam int PlaneWords = ImgWidth * ImgHeight;
   localparam int AddrBits = $clog2(PlaneWords);
   localparam int DivSteps = 62;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEM,
      ST_MUL,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic        neg_re;
      logic        neg_im;
      logic [31:0] mag_re;
      logic [31:0] mag_im;
      logic [31:0] divisor;
   } div_req_type;
endpackage

[hw/rtl/pnpp_ram.sv]
module pnpp_ram #(
   parameter int Depth = 16384,
   parameter int Width = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/pnpp_div.sv]
module pnpp_div import pnpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [31:0] q_re,
   output logic [31:0] q_im
);
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [61:0] nre_ff, nre_in, nim_ff, nim_in;
   logic [32:0] rre_ff, rre_in, rim_ff, rim_in;
   logic [61:0] qre_ff, qre_in, qim_ff, qim_in;
   logic [31:0] d_ff, d_in;
   logic        sre_ff, sre_in, sim_ff, sim_in;
   logic [32:0] tre, tim;
   logic        fin_ff;

   function automatic logic [31:0] sat(input logic [61:0] q, input logic neg);
      if (neg) begin
         sat = (q > 62'h80000000) ? 32'h80000000 : 32'(~q[31:0] + 32'd1);
      end else begin
         sat = (q > 62'h7fffffff) ? 32'h7fffffff : q[31:0];
      end
   endfunction

   always_comb begin
      cnt_in = cnt_ff; busy_in = busy_ff; nre_in = nre_ff; nim_in = nim_ff;
      rre_in = rre_ff; rim_in = rim_ff; qre_in = qre_ff; qim_in = qim_ff;
      d_in = d_ff; sre_in = sre_ff; sim_in = sim_ff;
      tre = {rre_ff[31:0], nre_ff[61]};
      tim = {rim_ff[31:0], nim_ff[61]};
      if (req.start) begin
         busy_in = 1'b1; cnt_in = '0;
         nre_in = {req.mag_re, 30'd0}; nim_in = {req.mag_im, 30'd0};
         rre_in = '0; rim_in = '0; qre_in = '0; qim_in = '0;
         d_in = req.divisor; sre_in = req.neg_re; sim_in = req.neg_im;
      end else if (busy_ff) begin
         nre_in = {nre_ff[60:0], 1'b0};
         nim_in = {nim_ff[60:0], 1'b0};
         if (tre >= {1'b0, d_ff}) begin
            rre_in = tre - {1'b0, d_ff}; qre_in = {qre_ff[60:0], 1'b1};
         end else begin
            rre_in = tre; qre_in = {qre_ff[60:0], 1'b0};
         end
         if (tim >= {1'b0, d_ff}) begin
            rim_in = tim - {1'b0, d_ff}; qim_in = {qim_ff[60:0], 1'b1};
         end else begin
            rim_in = tim; qim_in = {qim_ff[60:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DivSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      nre_ff <= nre_in; nim_ff <= nim_in; rre_ff <= rre_in; rim_ff <= rim_in;
      qre_ff <= qre_in; qim_ff <= qim_in; d_ff <= d_in;
      sre_ff <= sre_in; sim_ff <= sim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= busy_ff && !busy_in;
      end
   end
   assign q_re = sat(qre_ff, sre_ff);
   assign q_im = sat(qim_ff, sim_ff);
   assign done = fin_ff;
endmodule

[hw/rtl/peak_normalized_polar_products.sv]
// Sequential block: one word at a time. Load, clear and the unused opcode complete in the idle
// state. An accepted read passes through the memory, multiply and sum states; unnormalized, its
// result then goes to the output register, and with normalization it goes to a 62-step radix-2
// divider (real and imaginary in parallel) whose quotients are registered from the output state.
// Results wait in an output register, and a read that finds it still full holds until it drains.
module peak_normalized_polar_products import pnpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], plane[3:2], row[10:4], col[17:11], pixel_re[33:18], pixel_im[49:34]
   input  logic [55:0] req_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_re[31:0], out_im[63:32], normalized[64]
   output logic [71:0] rsp_tdata
);
   state_type   state_ff, state_in;
   logic [30:0] thr_ff;
   logic [31:0] peak_ff, peak_in;
   logic [1:0]  plane_ff;
   logic        inside_ff, norm_ff;
   logic signed [15:0] rr, ri, lr, li;
   logic signed [31:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [31:0] a0, a1, a2, a3;
   logic signed [33:0] pr_ff, pi_ff;
   logic [31:0] ore_ff, oim_ff;
   logic        onorm_ff, ovalid_ff;
   logic [31:0] rwd, lwd;
   div_req_type dreq;
   logic        ddone;
   logic [31:0] dq_re, dq_im;

   wire opcode_type op = opcode_type'(req_tdata[1:0]);
   wire [1:0]  pl = req_tdata[3:2];
   wire [RowBits-1:0] row = req_tdata[10:4];
   wire [ColBits-1:0] col = req_tdata[17:11];
   wire signed [15:0] pre = req_tdata[33:18];
   wire signed [15:0] pim = req_tdata[49:34];
   wire in_image = 1'b1;
   wire [AddrBits-1:0] addr = {row, col};
   wire [31:0] mag2 = 32'(pre * pre) + 32'(pim * pim);
   wire acc = req_tvalid && req_tready;
   wire wr = acc && op == OP_LOAD && in_image;

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   pnpp_ram #(.Depth(PlaneWords), .Width(32)) u_r (.clock, .wr_en(wr && pl == 2'd0),
      .wr_addr(addr), .wr_data({pre, pim}), .rd_addr(addr), .rd_data(rwd));
   pnpp_ram #(.Depth(PlaneWords), .Width(32)) u_l (.clock, .wr_en(wr && pl == 2'd3),
      .wr_addr(addr), .wr_data({pre, pim}), .rd_addr(addr), .rd_data(lwd));
   pnpp_div u_div (.clock, .reset, .req(dreq), .done(ddone), .q_re(dq_re), .q_im(dq_im));

   assign rr = rwd[31:16]; assign ri = rwd[15:0];
   assign lr = lwd[31:16]; assign li = lwd[15:0];

   always_comb begin
      a0 = 32'(rr); a1 = 32'(rr); a2 = 32'(ri); a3 = 32'(ri);
      unique case (plane_ff)
         2'd0: begin a0 = 32'(rr); a1 = 32'(rr); a2 = 32'(ri); a3 = 32'(ri); end
         2'd1: begin a0 = 32'(lr); a1 = 32'(rr); a2 = 32'(li); a3 = 32'(ri); end
         2'd2: begin a0 = 32'(rr); a1 = 32'(lr); a2 = 32'(ri); a3 = 32'(li); end
         default: begin a0 = 32'(lr); a1 = 32'(lr); a2 = 32'(li); a3 = 32'(li); end
      endcase
   end

   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      if (v > 34'sd2147483647) sat34 = 32'h7fffffff;
      else if (v < -34'sd2147483648) sat34 = 32'h80000000;
      else sat34 = v[31:0];
   endfunction

   wire [31:0] sre = sat34(pr_ff);
   wire [31:0] sim = sat34(pi_ff);

   always_comb begin
      state_in = state_ff;
      peak_in = peak_ff;
      dreq = '0;
      unique case (state_ff)
         ST_IDLE: if (acc) begin
            if (op == OP_LOAD && in_image && mag2 > peak_ff) peak_in = mag2;
            if (op == OP_CLEAR) peak_in = '0;
            if (op == OP_READ) state_in = ST_MEM;
         end
         ST_MEM: state_in = ST_MUL;
         ST_MUL: state_in = ST_SUM;
         ST_SUM: begin
            if (norm_ff && inside_ff) begin
               dreq.start = 1'b1;
               dreq.neg_re = sre[31]; dreq.neg_im = sim[31];
               dreq.mag_re = sre[31] ? 32'(~sre + 32'd1) : sre;
               dreq.mag_im = sim[31] ? 32'(~sim + 32'd1) : sim;
               dreq.divisor = peak_ff;
               state_in = ST_DIV;
            end else if (!ovalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: if (ddone) state_in = ST_OUT;
         ST_OUT: if (!ovalid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; peak_ff <= '0; thr_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; peak_ff <= peak_in;
         if (csr_valid) thr_ff <= csr_data;
         if ((state_ff == ST_SUM && state_in == ST_IDLE) ||
             (state_ff == ST_OUT && state_in == ST_IDLE)) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
      end
      if (acc) begin
         plane_ff <= pl; inside_ff <= in_image; norm_ff <= peak_ff > {1'b0, thr_ff};
      end
      m0_ff <= a0 * a1; m1_ff <= a2 * a3; m2_ff <= a2 * a1; m3_ff <= a0 * a3;
      if (state_ff == ST_MUL) begin
         pr_ff <= 34'(m0_ff) + ((plane_ff == 2'd0 || plane_ff == 2'd3) ?
                  -34'(m1_ff) : 34'(m1_ff));
         pi_ff <= (plane_ff == 2'd0 || plane_ff == 2'd3) ? 34'(m3_ff) + 34'(m3_ff) :
                  34'(m2_ff) - 34'(m3_ff);
      end
      if (state_ff == ST_SUM && state_in == ST_IDLE) begin
         ore_ff <= inside_ff ? sre : '0; oim_ff <= inside_ff ? sim : '0;
         onorm_ff <= norm_ff;
      end else if (state_ff == ST_OUT && state_in == ST_IDLE) begin
         ore_ff <= dq_re; oim_ff <= dq_im; onorm_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = {7'd0, onorm_ff, oim_ff, ore_ff};
endmodule

[hw/rtl/pnpp_checker.sv]
module pnpp_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [71:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp drop");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == 7'd0) else $error("pad");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid) else $error("rst");
   a_rst_ready: assert property (@(posedge clock) reset |=> req_tready) else $error("ready");
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tready)) else $error("ready x");
endmodule

bind peak_normalized_polar_products pnpp_checker u_chk (.clock, .reset, .req_tvalid,
   .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);
